>>> design/fpa_pkg.sv
// package for the q24.8 fixed-point alu: command codes and transaction structs
// no dependencies
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH = 32;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_MIN      = 4'd4,
        CMD_MAX      = 4'd5,
        CMD_INC      = 4'd6,
        CMD_DEC      = 4'd7,
        CMD_FROM_INT = 4'd8,
        CMD_TO_INT   = 4'd9
    } t_cmd;

    typedef struct packed {
        logic [3:0]               command;
        logic signed [FIELD_WIDTH-1:0] operand_a;
        logic signed [FIELD_WIDTH-1:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] result_value;
        logic                     a_greater;
        logic                     a_less;
        logic                     a_equal;
        logic                     divide_by_zero;
    } t_rsp;

endpackage

>>> design/fpa_div.sv
// pipelined signed divider: restoring, one quotient bit per stage, truncating
// depends on fpa_pkg only through the top level's parameters
module fpa_div #(
    parameter int NUM_WIDTH = 40,
    parameter int DEN_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic signed [NUM_WIDTH-1:0] i_num,
    input  logic signed [DEN_WIDTH-1:0] i_den,
    output logic        [NUM_WIDTH-1:0] o_quot,
    output logic                        o_neg
);
    localparam int RW = DEN_WIDTH + 1;

    logic [NUM_WIDTH-1:0] r_q   [NUM_WIDTH+1];
    logic [RW-1:0]        r_rem [NUM_WIDTH+1];
    logic [DEN_WIDTH-1:0] r_den [NUM_WIDTH+1];
    logic                 r_neg [NUM_WIDTH+1];

    // magnitudes into stage 0
    always_ff @(posedge i_clk) begin
        r_q[0]   <= i_num[NUM_WIDTH-1] ? NUM_WIDTH'(-i_num) : NUM_WIDTH'(i_num);
        r_den[0] <= i_den[DEN_WIDTH-1] ? DEN_WIDTH'(-i_den) : DEN_WIDTH'(i_den);
        r_rem[0] <= '0;
        r_neg[0] <= i_num[NUM_WIDTH-1] ^ i_den[DEN_WIDTH-1];
    end

    // one quotient bit per stage
    for (genvar s = 0; s < NUM_WIDTH; s++) begin : g_stage
        logic [RW:0]   w_shift;
        logic [RW:0]   w_diff;
        assign w_shift = {r_rem[s], r_q[s][NUM_WIDTH-1]};
        assign w_diff  = w_shift - {2'b00, r_den[s]};
        always_ff @(posedge i_clk) begin
            r_den[s+1] <= r_den[s];
            r_neg[s+1] <= r_neg[s];
            if (!w_diff[RW]) begin
                r_rem[s+1] <= w_diff[RW-1:0];
                r_q[s+1]   <= {r_q[s][NUM_WIDTH-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= w_shift[RW-1:0];
                r_q[s+1]   <= {r_q[s][NUM_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_q[NUM_WIDTH];
    assign o_neg  = r_neg[NUM_WIDTH];
endmodule

>>> design/fixed_point_q24_8_alu.sv
// top level of the q24.8 fixed-point alu
// depends on fpa_pkg and fpa_div
//
// usage: drive i_req with a command and two raw operands and raise start;
// busy is always low, so a transaction is taken every cycle start is high.
// every transaction gives one result on o_rsp, marked by o_done for one
// cycle, in order. between the accepting edge and o_done lie one capture
// stage, one stage into the divider, one stage per quotient bit and the
// output register. the divider sets this depth; all commands share it
// so results never reorder. throughput is one transaction per cycle.
// the multiplier is registered at its input and product, then delayed to
// match. reset clears only the valid bits along the pipeline; payload is
// left as is. the receiver cannot stall, so results are never held.
module fixed_point_q24_8_alu #(
    parameter int FRACTION_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH   = fpa_pkg::VALUE_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  fpa_pkg::t_req  i_req,
    output logic           o_done,
    output fpa_pkg::t_rsp  o_rsp
);
    localparam int VW   = VALUE_WIDTH;
    localparam int FW   = fpa_pkg::FIELD_WIDTH;
    localparam int NW   = VW + FRACTION_BITS;
    localparam int LAT  = NW + 2;
    localparam int PW   = 2 * VW;

    logic [LAT-2:0] r_vld;

    // operand capture, narrowed to the value width
    logic               r_v0;
    logic [3:0]         r_cmd0;
    logic signed [VW-1:0] r_a0, r_b0;

    always_ff @(posedge i_clk) begin
        r_cmd0 <= i_req.command;
        r_a0   <= VW'(i_req.operand_a);
        r_b0   <= VW'(i_req.operand_b);
    end

    // stage 1: simple results, compares, product
    logic signed [VW-1:0] n_simple;
    logic                 w_gt, w_lt, w_eq, w_isdiv, w_dz;
    always_comb begin
        w_gt = r_a0 > r_b0;
        w_lt = r_a0 < r_b0;
        w_eq = r_a0 == r_b0;
        w_isdiv = r_cmd0 == fpa_pkg::CMD_DIV;
        w_dz = w_isdiv && (r_b0 == '0);
        case (r_cmd0)
            fpa_pkg::CMD_ADD:      n_simple = r_a0 + r_b0;
            fpa_pkg::CMD_SUB:      n_simple = r_a0 - r_b0;
            fpa_pkg::CMD_MIN:      n_simple = w_lt ? r_a0 : r_b0;
            fpa_pkg::CMD_MAX:      n_simple = w_gt ? r_a0 : r_b0;
            fpa_pkg::CMD_INC:      n_simple = r_a0 + VW'(1);
            fpa_pkg::CMD_DEC:      n_simple = r_a0 - VW'(1);
            fpa_pkg::CMD_FROM_INT: n_simple = r_a0 <<< FRACTION_BITS;
            fpa_pkg::CMD_TO_INT:   n_simple = r_a0 >>> FRACTION_BITS;
            default:               n_simple = '0;
        endcase
    end

    logic [3:0]           r_cmd [LAT-1];
    logic signed [VW-1:0] r_simple [LAT-1];
    logic [3:0]           r_flg [LAT-1];
    logic signed [PW-1:0] r_prod [LAT-1];

    always_ff @(posedge i_clk) begin
        r_cmd[0]    <= r_cmd0;
        r_simple[0] <= n_simple;
        r_flg[0]    <= {w_gt, w_lt, w_eq, w_dz};
        r_prod[0]   <= PW'(r_a0) * PW'(r_b0);
    end

    // delay line matching the divider
    for (genvar s = 1; s < LAT - 1; s++) begin : g_dly
        always_ff @(posedge i_clk) begin
            r_cmd[s]    <= r_cmd[s-1];
            r_simple[s] <= r_simple[s-1];
            r_flg[s]    <= r_flg[s-1];
            r_prod[s]   <= r_prod[s-1];
        end
    end

    // divider, fed from the capture register
    logic [NW-1:0] w_quot;
    logic          w_qneg;
    logic signed [NW-1:0] w_num;
    assign w_num = NW'(r_a0) <<< FRACTION_BITS;
    fpa_div #(.NUM_WIDTH(NW), .DEN_WIDTH(VW)) u_div (
        .i_clk (i_clk),
        .i_num (w_num),
        .i_den (r_b0),
        .o_quot(w_quot),
        .o_neg (w_qneg)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_vld <= '0;
        end else begin
            r_v0  <= start;
            r_vld <= {r_vld[LAT-3:0], r_v0};
        end
    end

    // final select and output register
    logic signed [VW-1:0] n_res;
    logic [NW-1:0]        w_sq;
    logic                 r_done;
    fpa_pkg::t_rsp        r_rsp;
    always_comb begin
        w_sq = w_qneg ? NW'(-w_quot) : w_quot;
        case (r_cmd[LAT-2])
            fpa_pkg::CMD_MUL: n_res = VW'(r_prod[LAT-2] >>> FRACTION_BITS);
            fpa_pkg::CMD_DIV: n_res = r_flg[LAT-2][0] ? '0 : VW'(w_sq);
            default:          n_res = r_simple[LAT-2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[LAT-2];
        end
        r_rsp.result_value   <= FW'(n_res);
        r_rsp.a_greater      <= r_flg[LAT-2][3];
        r_rsp.a_less         <= r_flg[LAT-2][2];
        r_rsp.a_equal        <= r_flg[LAT-2][1];
        r_rsp.divide_by_zero <= r_flg[LAT-2][0];
    end

    assign busy   = 1'b0;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;
endmodule
